### hdl/lbw_pkg.sv
// Shared types, widths and register codes of the lens blend weight core.
`default_nettype none

package lbw_pkg;

   // field widths
   localparam int COORD_W    = 18;  // pixel / vertex coordinate, signed Q13.4
   localparam int ANG_W      = 20;  // ray angle, signed Q3.16
   localparam int FOV_W      = 19;  // half_fov, seam_shift, fov_feather
   localparam int RAMP_W     = 17;  // occlusion ramp, Q13.4
   localparam int FRAME_W    = 14;  // frame size in pixels
   localparam int WGT_W      = 17;  // weight, Q1.16
   localparam int VIDX_W     = 4;   // vertex_index field
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 19;
   localparam int NUM_LENSES = 2;

   // datapath widths
   localparam int TM_W   = 21;  // lens limit, signed
   localparam int DIFF_W = 19;  // coordinate difference, signed
   localparam int DX_W   = 20;  // offset to closest point, signed
   localparam int PRD_W  = 40;  // product register, signed
   localparam int SUM_W  = 41;  // sum of two products, signed
   localparam int BEST_W = 41;  // squared distance, unsigned
   localparam int DIV_W  = 38;  // divider operand width
   localparam int QUO_W  = 16;  // fraction bits out of the divider
   localparam int ROOT_W = 25;  // square root result
   localparam int RAD_W  = 2 * ROOT_W;

   localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HALF_FOV       = 4'd0,
      REG_SEAM_SHIFT     = 4'd1,
      REG_FOV_FEATHER    = 4'd2,
      REG_OCCLUSION_RAMP = 4'd3,
      REG_USE_OCCLUSION  = 4'd4,
      REG_FRAME_WIDTH    = 4'd5,
      REG_FRAME_HEIGHT   = 4'd6,
      REG_MASTER_LENS    = 4'd7
   } csr_reg_type;

   typedef enum logic {
      KIND_QUERY = 1'b0,
      KIND_LOAD  = 1'b1
   } kind_type;

   // vertex write into the polygon store
   typedef struct packed {
      logic                      en;
      logic                      lens;
      logic [VIDX_W-1:0]         index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } vwr_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

endpackage

`default_nettype wire

### hdl/lbw_div.sv
// Radix-2 fraction divider: floor(num * 2^16 / den) for num < den.
`default_nettype none

module lbw_div
   import lbw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   input  wire logic [DIV_W-1:0] den,
   output logic                  done,
   output logic [QUO_W-1:0]      quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in, den_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIV_W:0]   shifted, trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      trial   = shifted - {1'b0, den_ff};
      rem_in  = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

### hdl/lbw_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
`default_nettype none

module lbw_sqrt
   import lbw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [RAD_W-1:0] radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [ROOT_W+2:0] rem_sh, trial, rem_sub;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

### hdl/lbw_vstore.sv
// Polygon vertex memory of both lenses and the per-lens vertex counts.
`default_nettype none

module lbw_vstore
   import lbw_pkg::*;
#(
   parameter  int MAX_VERTS = 16,
   localparam int IW        = $clog2(MAX_VERTS),
   localparam int CW        = $clog2(MAX_VERTS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire vwr_type       wr,
   input  wire logic          rd_lens,
   input  wire logic [IW-1:0] rd_index,
   output vertex_type         rd_data,
   input  wire logic          cnt_lens,
   output logic [CW-1:0]      count
);

   localparam int DEPTH = NUM_LENSES * MAX_VERTS;
   localparam int AW    = $clog2(DEPTH);

   logic signed [COORD_W-1:0] mem_x [DEPTH];
   logic signed [COORD_W-1:0] mem_y [DEPTH];
   logic [CW-1:0]             count_ff [NUM_LENSES];
   vertex_type                rd_ff;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic                      wr_ok;

   always_comb begin
      wr_ok   = wr.en && ({28'b0, wr.index} < 32'(MAX_VERTS));
      wr_addr = AW'(wr.lens) * AW'(MAX_VERTS) + AW'(wr.index);
      rd_addr = AW'(rd_lens) * AW'(MAX_VERTS) + AW'(rd_index);
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_x[wr_addr] <= wr.x;
         mem_y[wr_addr] <= wr.y;
      end
      rd_ff.x <= mem_x[rd_addr];
      rd_ff.y <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LENSES; k++) begin
            count_ff[k] <= '0;
         end
      end else if (wr_ok && wr.last) begin
         count_ff[wr.lens] <= CW'(wr.index) + CW'(1);
      end
   end

   assign rd_data = rd_ff;
   assign count   = count_ff[cnt_lens];

endmodule

`default_nettype wire

### hdl/lens_blend_weight_core.sv
// Top level of the lens blend weight core: sequencer, datapath and ports.
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_*     in         req_valid/stall    kind, lens, theta, pixel_x/y, vertex_*
// rsp_*     out        rsp_valid/stall    weight (Q1.16)
// csr_*     in         csr_valid/ready    index, data (register write)
//
// A vertex load is written while the sequencer is idle. A query runs the
// range checks, then the feather division and multiply, then, with
// occlusion on, for an n-vertex polygon the edge work, a division for each
// edge whose closest-point fraction needs the divider, the square root and
// the ramp division. All three divisions share the 16-step divider, and
// the vertex memory read port feeds one vertex to the edge work at a time.
// Reset is synchronous; it clears the counts and the control state, the
// vertex memory holds garbage until loaded. A finished weight waits in the
// output register while the next item is taken; rsp_stall only blocks when
// a second weight is ready before the first one is transferred.

module lens_blend_weight_core
   import lbw_pkg::*;
#(
   parameter int MAX_VERTS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_kind,
   input  wire logic                      req_lens,
   input  wire logic signed [ANG_W-1:0]   req_theta,
   input  wire logic signed [COORD_W-1:0] req_pixel_x,
   input  wire logic signed [COORD_W-1:0] req_pixel_y,
   input  wire logic [VIDX_W-1:0]         req_vertex_index,
   input  wire logic signed [COORD_W-1:0] req_vertex_x,
   input  wire logic signed [COORD_W-1:0] req_vertex_y,
   input  wire logic                      req_vertex_last,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [WGT_W-1:0]               rsp_weight,
   // register write channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_FDIV, ST_FMUL1, ST_FMUL2, ST_FMUL3, ST_OCC,
      ST_PREV, ST_LOADB, ST_M1, ST_M2, ST_M3, ST_M4, ST_EDIV, ST_C1, ST_C2,
      ST_C3, ST_C4, ST_SQSTART, ST_SQWAIT, ST_ODIV, ST_FINAL, ST_DONE
   } state_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [FOV_W-1:0]         half_fov_ff, feather_ff;
   logic signed [FOV_W-1:0]  seam_ff;
   logic [RAMP_W-1:0]        ramp_ff;
   logic                     use_occ_ff, master_ff;
   logic [FRAME_W-1:0]       fw_ff, fh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_fov_ff <= FOV_W'(205887);
         seam_ff     <= '0;
         feather_ff  <= '0;
         ramp_ff     <= '0;
         use_occ_ff  <= 1'b0;
         fw_ff       <= FRAME_W'(1920);
         fh_ff       <= FRAME_W'(1080);
         master_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HALF_FOV:       half_fov_ff <= csr_data[FOV_W-1:0];
            REG_SEAM_SHIFT:     seam_ff     <= $signed(csr_data[FOV_W-1:0]);
            REG_FOV_FEATHER:    feather_ff  <= csr_data[FOV_W-1:0];
            REG_OCCLUSION_RAMP: ramp_ff     <= csr_data[RAMP_W-1:0];
            REG_USE_OCCLUSION:  use_occ_ff  <= csr_data[0];
            REG_FRAME_WIDTH:    fw_ff       <= csr_data[FRAME_W-1:0];
            REG_FRAME_HEIGHT:   fh_ff       <= csr_data[FRAME_W-1:0];
            REG_MASTER_LENS:    master_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------
   state_type                state_ff;
   logic                     lens_ff;
   logic signed [ANG_W-1:0]  theta_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DIFF_W-1:0] abx_ff, aby_ff, apx_ff, apy_ff, qx_ff, qy_ff;
   logic signed [PRD_W-1:0]  p1_ff, p2_ff;
   logic signed [SUM_W-1:0]  len2_ff, dot_ff;
   logic signed [DX_W-1:0]   dx_ff, dy_ff;
   logic [BEST_W-1:0]        best_ff;
   logic [WGT_W-1:0]         w_ff, t_ff, u_ff, occ_ff;
   logic [33:0]              tt_ff;
   logic [51:0]              fp_ff;
   logic                     cross_ff, denpos_ff, inside_ff;
   logic [IW-1:0]            idx_ff;
   logic                     rsp_valid_ff;
   logic [WGT_W-1:0]         rsp_weight_ff;

   // ---------------------------------------------------------------
   // submodules
   // ---------------------------------------------------------------
   vwr_type          vwr;
   vertex_type       vrd;
   logic [IW-1:0]    rd_index;
   logic [CW-1:0]    count;
   logic             div_start, div_done, sq_start, sq_done;
   logic [DIV_W-1:0] div_num, div_den;
   logic [QUO_W-1:0] quo;
   logic [ROOT_W-1:0] root;

   always_comb begin
      vwr.en    = (state_ff == ST_IDLE) && req_valid && (req_kind == KIND_LOAD);
      vwr.lens  = req_lens;
      vwr.index = req_vertex_index;
      vwr.x     = req_vertex_x;
      vwr.y     = req_vertex_y;
      vwr.last  = req_vertex_last;
   end

   lbw_vstore #(.MAX_VERTS(MAX_VERTS)) u_vstore (
      .clock    (clock),
      .reset    (reset),
      .wr       (vwr),
      .rd_lens  (lens_ff),
      .rd_index (rd_index),
      .rd_data  (vrd),
      .cnt_lens (lens_ff),
      .count    (count)
   );

   lbw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   lbw_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (RAD_W'({best_ff, 8'b0})),
      .done     (sq_done),
      .root     (root)
   );

   // ---------------------------------------------------------------
   // query checks and feather setup
   // ---------------------------------------------------------------
   logic signed [TM_W-1:0] tmax;
   logic signed [21:0]     start_ang;
   logic signed [22:0]     fdiff;
   logic                   out_zero, feather_act, feather_full;
   logic [20:0]            ramp16;
   logic                   last_edge, u_div_need, root_ge_ramp;
   logic                   occ_on;
   logic signed [PRD_W-1:0] rnd_x, rnd_y;
   logic [BEST_W-1:0]      d2;
   logic [51:0]            fp_rnd;
   logic [33:0]            wo_prod;

   always_comb begin
      tmax = TM_W'($signed({1'b0, half_fov_ff}))
           + ((lens_ff == master_ff) ? TM_W'(seam_ff) : -TM_W'(seam_ff));
      start_ang = 22'(tmax) - 22'($signed({1'b0, feather_ff}));
      fdiff     = 23'(theta_ff) - 23'(start_ang);
      out_zero  = theta_ff[ANG_W-1] || px_ff[COORD_W-1] || py_ff[COORD_W-1]
               || ($unsigned(px_ff) >= {fw_ff, 4'b0})
               || ($unsigned(py_ff) >= {fh_ff, 4'b0})
               || tmax[TM_W-1] || (tmax == '0)
               || (TM_W'(theta_ff) > tmax);
      feather_act  = (feather_ff != '0) && (22'(theta_ff) > start_ang);
      feather_full = fdiff >= 23'($signed({1'b0, feather_ff}));
      occ_on       = use_occ_ff && (count >= CW'(3));
      u_div_need   = (len2_ff != '0) && !dot_ff[SUM_W-1] && (dot_ff != '0)
                  && (dot_ff < len2_ff);
      ramp16       = {ramp_ff, 4'b0};
      root_ge_ramp = root >= ROOT_W'(ramp16);
      last_edge    = idx_ff == IW'(count - CW'(1));
      rnd_x        = (p1_ff + $signed(PRD_W'(32768))) >>> 16;
      rnd_y        = (p2_ff + $signed(PRD_W'(32768))) >>> 16;
      d2           = BEST_W'(p1_ff) + BEST_W'(p2_ff);
      fp_rnd       = fp_ff + 52'h0_0000_8000_0000;
      wo_prod      = w_ff * occ_ff;
   end

   // shared divider and root unit launches
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      sq_start  = 1'b0;
      case (state_ff)
         ST_CHECK: begin
            if (!out_zero && feather_act && !feather_full) begin
               div_start = 1'b1;
               div_num   = DIV_W'(fdiff[FOV_W-1:0]);
               div_den   = DIV_W'(feather_ff);
            end
         end
         ST_M4: begin
            if (u_div_need) begin
               div_start = 1'b1;
               div_num   = DIV_W'(dot_ff);
               div_den   = DIV_W'(len2_ff);
            end
         end
         ST_SQSTART: sq_start = !inside_ff;
         ST_SQWAIT: begin
            if (sq_done && (ramp_ff != '0) && !root_ge_ramp) begin
               div_start = 1'b1;
               div_num   = DIV_W'(root);
               div_den   = DIV_W'(ramp16);
            end
         end
         default: ;
      endcase
   end

   // memory read address: the registered word shows up in the following cycle
   always_comb begin
      case (state_ff)
         ST_OCC:  rd_index = IW'(count - CW'(1));
         ST_PREV: rd_index = '0;
         ST_C4:   rd_index = idx_ff + IW'(1);
         default: rd_index = idx_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_DONE reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_kind == KIND_QUERY)) begin
                  lens_ff  <= req_lens;
                  theta_ff <= req_theta;
                  px_ff    <= req_pixel_x;
                  py_ff    <= req_pixel_y;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (out_zero) begin
                  w_ff     <= '0;
                  state_ff <= ST_DONE;
               end else if (feather_act) begin
                  if (feather_full) begin
                     t_ff     <= WGT_ONE;
                     state_ff <= ST_FMUL1;
                  end else begin
                     state_ff <= ST_FDIV;
                  end
               end else begin
                  w_ff     <= WGT_ONE;
                  state_ff <= ST_OCC;
               end
            end
            ST_FDIV: begin
               if (div_done) begin
                  t_ff     <= {1'b0, quo};
                  state_ff <= ST_FMUL1;
               end
            end
            ST_FMUL1: begin
               tt_ff    <= t_ff * t_ff;
               state_ff <= ST_FMUL2;
            end
            ST_FMUL2: begin
               // smoothstep: t^2 * (3 - 2t)
               fp_ff    <= tt_ff * (18'(196608) - {t_ff, 1'b0});
               state_ff <= ST_FMUL3;
            end
            ST_FMUL3: begin
               w_ff     <= WGT_ONE - fp_rnd[48:32];
               state_ff <= ST_OCC;
            end
            ST_OCC: begin
               if (occ_on) begin
                  best_ff   <= '1;
                  inside_ff <= 1'b0;
                  idx_ff    <= '0;
                  state_ff  <= ST_PREV;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_PREV: begin
               // closing edge starts at the last vertex
               ax_ff    <= vrd.x;
               ay_ff    <= vrd.y;
               state_ff <= ST_LOADB;
            end
            ST_LOADB: begin
               bx_ff     <= vrd.x;
               by_ff     <= vrd.y;
               abx_ff    <= DIFF_W'(vrd.x) - DIFF_W'(ax_ff);
               aby_ff    <= DIFF_W'(vrd.y) - DIFF_W'(ay_ff);
               apx_ff    <= DIFF_W'(px_ff) - DIFF_W'(ax_ff);
               apy_ff    <= DIFF_W'(py_ff) - DIFF_W'(ay_ff);
               qx_ff     <= DIFF_W'(px_ff) - DIFF_W'(vrd.x);
               qy_ff     <= DIFF_W'(py_ff) - DIFF_W'(vrd.y);
               cross_ff  <= (vrd.y > py_ff) != (ay_ff > py_ff);
               denpos_ff <= ay_ff > vrd.y;
               state_ff  <= ST_M1;
            end
            ST_M1: begin
               p1_ff    <= PRD_W'(abx_ff * abx_ff);
               p2_ff    <= PRD_W'(aby_ff * aby_ff);
               state_ff <= ST_M2;
            end
            ST_M2: begin
               len2_ff  <= SUM_W'(p1_ff) + SUM_W'(p2_ff);
               p1_ff    <= PRD_W'(apx_ff * abx_ff);
               p2_ff    <= PRD_W'(apy_ff * aby_ff);
               state_ff <= ST_M3;
            end
            ST_M3: begin
               dot_ff   <= SUM_W'(p1_ff) + SUM_W'(p2_ff);
               // crossing terms: num in p1, lhs in p2
               p1_ff    <= PRD_W'(qy_ff * DIFF_W'(-abx_ff));
               p2_ff    <= PRD_W'(qx_ff * DIFF_W'(-aby_ff));
               state_ff <= ST_M4;
            end
            ST_M4: begin
               if (cross_ff && (denpos_ff ? (p2_ff < p1_ff) : (p2_ff > p1_ff))) begin
                  inside_ff <= !inside_ff;
               end
               if (u_div_need) begin
                  state_ff <= ST_EDIV;
               end else begin
                  // degenerate edge or point behind a: u = 0; past b: u = 1
                  u_ff     <= ((len2_ff != '0) && !dot_ff[SUM_W-1] && (dot_ff != '0))
                              ? WGT_ONE : '0;
                  state_ff <= ST_C1;
               end
            end
            ST_EDIV: begin
               if (div_done) begin
                  u_ff     <= {1'b0, quo};
                  state_ff <= ST_C1;
               end
            end
            ST_C1: begin
               p1_ff    <= PRD_W'(abx_ff * $signed({1'b0, u_ff}));
               p2_ff    <= PRD_W'(aby_ff * $signed({1'b0, u_ff}));
               state_ff <= ST_C2;
            end
            ST_C2: begin
               dx_ff    <= DX_W'(px_ff) - DX_W'(ax_ff) - DX_W'(rnd_x);
               dy_ff    <= DX_W'(py_ff) - DX_W'(ay_ff) - DX_W'(rnd_y);
               state_ff <= ST_C3;
            end
            ST_C3: begin
               p1_ff    <= PRD_W'(dx_ff * dx_ff);
               p2_ff    <= PRD_W'(dy_ff * dy_ff);
               state_ff <= ST_C4;
            end
            ST_C4: begin
               if (d2 < best_ff) begin
                  best_ff <= d2;
               end
               ax_ff <= bx_ff;
               ay_ff <= by_ff;
               if (last_edge) begin
                  state_ff <= ST_SQSTART;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= ST_LOADB;
               end
            end
            ST_SQSTART: begin
               if (inside_ff) begin
                  occ_ff   <= '0;
                  state_ff <= ST_FINAL;
               end else begin
                  state_ff <= ST_SQWAIT;
               end
            end
            ST_SQWAIT: begin
               if (sq_done) begin
                  if (ramp_ff == '0) begin
                     occ_ff   <= (root != '0) ? WGT_ONE : '0;
                     state_ff <= ST_FINAL;
                  end else if (root_ge_ramp) begin
                     occ_ff   <= WGT_ONE;
                     state_ff <= ST_FINAL;
                  end else begin
                     state_ff <= ST_ODIV;
                  end
               end
            end
            ST_ODIV: begin
               if (div_done) begin
                  occ_ff   <= {1'b0, quo};
                  state_ff <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               w_ff     <= wo_prod[32:16];
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hand over once the output register is free or draining
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_weight_ff <= w_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall  = state_ff != ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the lens blend weight core.
`default_nettype none

module testbench;
   import lbw_pkg::*;

   localparam int NVERT = 16;
   localparam int DRAIN_CYCLES = 600;

   typedef struct {
      kind_type                  kind;
      logic                      lens;
      logic signed [ANG_W-1:0]   theta;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [VIDX_W-1:0]         vidx;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
      logic                      last;
   } lens_item_type;

   logic clock;
   logic reset;
   logic req_valid, req_stall;
   logic req_kind, req_lens, req_vertex_last;
   logic signed [ANG_W-1:0]   req_theta;
   logic signed [COORD_W-1:0] req_pixel_x, req_pixel_y, req_vertex_x, req_vertex_y;
   logic [VIDX_W-1:0]         req_vertex_index;
   logic rsp_valid, rsp_stall;
   logic [WGT_W-1:0] rsp_weight;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   lens_blend_weight_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_lens(req_lens), .req_theta(req_theta), .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y), .req_vertex_index(req_vertex_index),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_last(req_vertex_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight(rsp_weight),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // pending transfers for the driver, expected weights for the monitor
   lens_item_type    pending_items[$];
   logic [WGT_W-1:0] expected_weights[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_used;
   int hold_cnt;

   // shadow configuration
   longint m_half_fov, m_seam, m_feather, m_ramp, m_use_occ, m_fw, m_fh, m_master;
   // shadow polygon store, indexed lens*NVERT+index
   longint m_px[2*NVERT];
   longint m_py[2*NVERT];
   int     m_count[2];
   // which entries the generator has already loaded, per lens
   logic [NVERT-1:0] gen_written[2];

   always #5 clock = ~clock;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint int_sqrt(input longint v);
      longint res, bit_v;
      res = 0;
      bit_v = 64'sd1 <<< 62;
      while (bit_v > v) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >>> 1) + bit_v;
         end else begin
            res = res >>> 1;
         end
         bit_v = bit_v >>> 2;
      end
      return res;
   endfunction

   // squared distance from p to segment a-b, Q.8 units
   function automatic longint edge_dist2(input longint ax, ay, bx, by, px, py);
      longint abx, aby, apx, apy, len2, dot, u, cx, cy, dx, dy;
      abx = bx - ax; aby = by - ay;
      apx = px - ax; apy = py - ay;
      len2 = abx * abx + aby * aby;
      if (len2 <= 0) return apx * apx + apy * apy;
      dot = apx * abx + apy * aby;
      if (dot <= 0) u = 0;
      else if (dot >= len2) u = 65536;
      else u = (dot <<< 16) / len2;
      cx = ax + ((abx * u + 32768) >>> 16);
      cy = ay + ((aby * u + 32768) >>> 16);
      dx = px - cx; dy = py - cy;
      return dx * dx + dy * dy;
   endfunction

   function automatic longint occlusion_gain(input int ln, input longint px, py);
      int n, j, base;
      longint best, d2, den, num, lhs, d;
      logic in_poly;
      n = m_count[ln];
      base = ln * NVERT;
      best = 64'h7fff_ffff_ffff_ffff;
      in_poly = 1'b0;
      for (int i = 0; i < n; i++) begin
         j = (i == 0) ? n - 1 : i - 1;
         d2 = edge_dist2(m_px[base+j], m_py[base+j], m_px[base+i], m_py[base+i], px, py);
         if (d2 < best) best = d2;
         if ((m_py[base+i] > py) != (m_py[base+j] > py)) begin
            den = m_py[base+j] - m_py[base+i];
            num = (py - m_py[base+i]) * (m_px[base+j] - m_px[base+i]);
            lhs = (px - m_px[base+i]) * den;
            if (den > 0 ? (lhs < num) : (lhs > num)) in_poly = ~in_poly;
         end
      end
      if (in_poly) return 0;
      d = int_sqrt(best <<< 8);
      if (m_ramp == 0) return (d > 0) ? 65536 : 0;
      d = (d <<< 16) / (m_ramp <<< 4);
      return (d > 65536) ? 65536 : d;
   endfunction

   function automatic logic [WGT_W-1:0] blend_weight(input lens_item_type it);
      longint th, px, py, tmax, start, t, s, w;
      th = it.theta; px = it.px; py = it.py;
      w = 65536;
      tmax = m_half_fov + ((it.lens == m_master[0]) ? m_seam : -m_seam);
      if (th < 0 || px < 0 || py < 0 || px >= (m_fw <<< 4) || py >= (m_fh <<< 4)
          || tmax <= 0 || th > tmax)
         return '0;
      if (m_feather > 0) begin
         start = tmax - m_feather;
         if (th > start) begin
            t = ((th - start) <<< 16) / m_feather;
            if (t > 65536) t = 65536;
            s = (t * t * (196608 - 2 * t) + (64'sd1 <<< 31)) >>> 32;
            w = 65536 - s;
         end
      end
      if (m_use_occ != 0 && m_count[it.lens] >= 3)
         w = (w * occlusion_gain(it.lens, px, py)) >>> 16;
      if (w > 65536) w = 65536;
      return WGT_W'(w);
   endfunction

   // one transfer accepted: update the shadow store or queue a weight
   task automatic take_item(input lens_item_type it);
      int slot;
      if (it.kind == KIND_LOAD) begin
         slot = it.lens * NVERT + it.vidx;
         m_px[slot] = it.vx;
         m_py[slot] = it.vy;
         if (it.last) m_count[it.lens] = it.vidx + 1;
      end else begin
         expected_weights.push_back(blend_weight(it));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            take_item(pending_items[0]);
            void'(pending_items.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid        <= 1'b1;
               req_kind         <= pending_items[0].kind;
               req_lens         <= pending_items[0].lens;
               req_theta        <= pending_items[0].theta;
               req_pixel_x      <= pending_items[0].px;
               req_pixel_y      <= pending_items[0].py;
               req_vertex_index <= pending_items[0].vidx;
               req_vertex_x     <= pending_items[0].vx;
               req_vertex_y     <= pending_items[0].vy;
               req_vertex_last  <= pending_items[0].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, fires once when armed
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt  <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_cnt  <= 3000;
         hold_used <= 1'b1;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_weights.size() == 0)
               report($sformatf("weight %0d with nothing expected", rsp_weight));
            else if (rsp_weight !== expected_weights[0])
               report($sformatf("weight %0d, expected %0d", rsp_weight, expected_weights[0]));
            if (expected_weights.size() != 0) void'(expected_weights.pop_front());
         end
         rsp_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_HALF_FOV:       m_half_fov = val & 64'h7ffff;
         REG_SEAM_SHIFT:     m_seam = longint'($signed(FOV_W'(val)));
         REG_FOV_FEATHER:    m_feather = val & 64'h7ffff;
         REG_OCCLUSION_RAMP: m_ramp = val & 64'h1ffff;
         REG_USE_OCCLUSION:  m_use_occ = val & 1;
         REG_FRAME_WIDTH:    m_fw = val & 64'h3fff;
         REG_FRAME_HEIGHT:   m_fh = val & 64'h3fff;
         REG_MASTER_LENS:    m_master = val & 1;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input longint hf, sh, fe, rp, uo, fw, fh, ms);
      write_reg(REG_HALF_FOV, hf);
      write_reg(REG_SEAM_SHIFT, sh);
      write_reg(REG_FOV_FEATHER, fe);
      write_reg(REG_OCCLUSION_RAMP, rp);
      write_reg(REG_USE_OCCLUSION, uo);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_MASTER_LENS, ms);
      // unused index, must be ignored
      write_reg(CSR_IDX_W'($urandom_range(8, 15)), $urandom);
   endtask

   // wait for the block to go quiet: nothing queued, nothing owed
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_weights.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic lens_item_type blank_item();
      lens_item_type it;
      it.kind = KIND_QUERY;
      it.lens = 1'($urandom_range(1));
      it.theta = ANG_W'($urandom);
      it.px = COORD_W'($urandom);
      it.py = COORD_W'($urandom);
      it.vidx = VIDX_W'($urandom);
      it.vx = COORD_W'($urandom);
      it.vy = COORD_W'($urandom);
      it.last = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic longint clip_coord(input longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   task automatic push_vertex(input logic ln, input int idx, input longint x, y,
                              input logic last);
      lens_item_type it;
      it = blank_item();
      it.kind = KIND_LOAD;
      it.lens = ln;
      it.vidx = VIDX_W'(idx);
      it.vx = COORD_W'(x);
      it.vy = COORD_W'(y);
      it.last = last;
      gen_written[ln][idx] = 1'b1;
      pending_items.push_back(it);
   endtask

   task automatic push_query(input logic ln, input longint th, x, y);
      lens_item_type it;
      it = blank_item();
      it.kind = KIND_QUERY;
      it.lens = ln;
      it.theta = ANG_W'(th);
      it.px = COORD_W'(x);
      it.py = COORD_W'(y);
      pending_items.push_back(it);
   endtask

   // a whole polygon, indexes 0..n-1, closed by the last flag
   task automatic push_polygon(input logic ln, input int n);
      longint cx, cy, rad, span;
      logic wild;
      span = (m_fw == 0) ? 1920 * 16 : m_fw * 16;
      cx = $urandom_range(0, span);
      cy = $urandom_range(0, (m_fh == 0) ? 1080 * 16 : m_fh * 16);
      rad = $urandom_range(16, 6000);
      wild = ($urandom_range(9) == 0);
      for (int i = 0; i < n; i++) begin
         if (wild)
            push_vertex(ln, i, longint'($signed(COORD_W'($urandom))),
                        longint'($signed(COORD_W'($urandom))), i == n - 1);
         else
            push_vertex(ln, i, clip_coord(cx + $signed($urandom_range(0, 2 * rad)) - rad),
                        clip_coord(cy + $signed($urandom_range(0, 2 * rad)) - rad), i == n - 1);
      end
   endtask

   task automatic random_phase(input int count);
      int r, n, k;
      longint lim, tmax, th, x, y;
      logic ln;
      logic [NVERT-1:0] low_mask;
      for (int c = 0; c < count; c++) begin
         r = $urandom_range(99);
         ln = 1'($urandom_range(1));
         if (r < 8) begin
            r = $urandom_range(99);
            n = (r < 70) ? $urandom_range(3, 6) : (r < 90) ? $urandom_range(7, 16)
                                                            : $urandom_range(1, 2);
            push_polygon(ln, n);
            c += n - 1;
         end else if (r < 13) begin
            // stray vertex load; close only over entries already loaded
            k = $urandom_range(0, NVERT - 1);
            push_vertex(ln, k, longint'($signed(COORD_W'($urandom))),
                        longint'($signed(COORD_W'($urandom))), 1'b0);
            low_mask = NVERT'((64'd1 << (k + 1)) - 64'd1);
            if ($urandom_range(3) == 0 && ((gen_written[ln] & low_mask) == low_mask)) begin
               pending_items[$].last = 1'b1;
            end
         end else begin
            tmax = m_half_fov + ((ln == m_master[0]) ? m_seam : -m_seam);
            lim = (tmax > 0 ? tmax : 0) + 2000;
            if (lim > 524287) lim = 524287;
            r = $urandom_range(99);
            if (r < 15) th = longint'($signed(ANG_W'($urandom)));
            else if (r < 55 && tmax > 0)
               th = tmax - $urandom_range(0, (m_feather > 0 ? m_feather : 100) + 50) + 10;
            else th = $urandom_range(0, lim);
            if (th > 524287) th = 524287;
            if (th < -524288) th = -524288;
            if ($urandom_range(9) == 0) begin
               x = longint'($signed(COORD_W'($urandom)));
               y = longint'($signed(COORD_W'($urandom)));
            end else begin
               x = clip_coord($urandom_range(0, (m_fw == 0 ? 1920 : m_fw) * 16 + 40));
               y = clip_coord($urandom_range(0, (m_fh == 0 ? 1080 : m_fh) * 16 + 40));
            end
            push_query(ln, th, x, y);
         end
      end
   endtask

   // run limit
   initial begin
      #80_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      m_half_fov = 205887; m_seam = 0; m_feather = 0; m_ramp = 0;
      m_use_occ = 0; m_fw = 1920; m_fh = 1080; m_master = 0;
      gen_written[0] = '0; gen_written[1] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a 100-pixel square on lens 0, a two-vertex polygon on lens 1
      set_config(205887, 1000, 20000, 160, 1, 1920, 1080, 0);
      push_vertex(1'b0, 0, 0, 0, 1'b0);
      push_vertex(1'b0, 1, 1600, 0, 1'b0);
      push_vertex(1'b0, 2, 1600, 1600, 1'b0);
      push_vertex(1'b0, 3, 0, 1600, 1'b1);
      push_vertex(1'b1, 0, 100, 100, 1'b0);
      push_vertex(1'b1, 1, 900, 900, 1'b1);
      push_query(1'b0, 1000, 800, 800);            // inside the polygon
      push_query(1'b0, 1000, 3200, 800);           // outside, beyond the ramp
      push_query(1'b0, 1000, 1700, 800);           // outside, within the ramp
      push_query(1'b0, 1000, 1600, 800);           // on an edge
      push_query(1'b0, -1, 3200, 3200);            // negative angle
      push_query(1'b0, 206887, 3200, 3200);        // exactly at the limit
      push_query(1'b0, 206888, 3200, 3200);        // just past the limit
      push_query(1'b1, 204887, 3200, 3200);        // non-master limit
      push_query(1'b0, 190000, 3200, 3200);        // inside the feather
      push_query(1'b1, 0, -16, 100);               // left of the frame
      push_query(1'b1, 0, 1920 * 16, 100);         // right frame edge
      push_query(1'b1, 0, 100, 1080 * 16 - 1);     // last row
      push_query(1'b1, 524287, 131071, 131071);    // field extremes
      push_query(1'b1, -524288, -131072, -131072);
      push_query(1'b1, 50, 200, 200);              // short polygon, no occlusion
      // zero-length edge: duplicated vertex
      push_vertex(1'b1, 2, 900, 900, 1'b0);
      push_vertex(1'b1, 3, 100, 900, 1'b1);
      push_query(1'b1, 50, 4000, 4000);
      push_query(1'b1, 50, 400, 800);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         case (ph)
            0: set_config(205887, 0, 0, 0, 1, 1920, 1080, 0);
            1: set_config(524287, 262143, 524287, 131071, 1, 8192, 8192, 1);
            2: set_config(0, -262144, 1, 1, 1, 1, 1, 0);
            3: set_config(100000, -5000, 30000, 64, 1, 640, 480, 1);
            4: set_config(300000, 20000, 100000, 0, 0, 1920, 1080, 0);
            5: set_config(50000, 60000, 2000, 2000, 1, 0, 0, 1);
            6: set_config($urandom_range(0, 524287), $signed($urandom_range(0, 524287)) - 262144,
                          $urandom_range(0, 524287), $urandom_range(0, 131071), 1,
                          $urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(1));
            default: set_config(150000, 0, 150000, 320, 1, 4096, 2160, 0);
         endcase
         // receiver holds off while the sender keeps offering
         if (ph == 0) hold_go <= 1'b1;
         random_phase(235);
         drain();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

### lens_blend_weight_core.f
hdl/lbw_pkg.sv
hdl/lbw_div.sv
hdl/lbw_sqrt.sv
hdl/lbw_vstore.sv
hdl/lens_blend_weight_core.sv
sim/testbench.sv
